// ===== rtl/egcd_pkg.sv =====
// Package for the extended GCD core: data widths, coefficient type and
// sequencer states. No dependencies.
`timescale 1ns / 1ps

package egcd_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned COEF_W = DATA_W + 1;
  localparam int unsigned CNT_W  = $clog2(DATA_W);

  typedef logic [DATA_W-1:0]        data_t;
  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic [CNT_W-1:0]         cnt_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_WAIT,
    ST_FIN
  } egcd_state_e;

endpackage

// ===== rtl/egcd_div_unit.sv =====
// Radix-2 restoring divider with two shift-add accumulators that form
// s*q and t*q from the quotient bits as they emerge. Uses egcd_pkg.
`timescale 1ns / 1ps

module egcd_div_unit import egcd_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  data_t dividend_i,
  input  data_t divisor_i,
  input  coef_t mul_s_i,
  input  coef_t mul_t_i,
  output logic  done_o,
  output data_t rem_o,
  output coef_t prod_s_o,
  output coef_t prod_t_o
);

  logic  busy_q, busy_d;
  logic  done_q, done_d;
  cnt_t  cnt_q, cnt_d;
  data_t rem_q, rem_d;
  data_t quo_q, quo_d;
  data_t dvs_q, dvs_d;
  coef_t mul_s_q, mul_s_d;
  coef_t mul_t_q, mul_t_d;
  coef_t acc_s_q, acc_s_d;
  coef_t acc_t_q, acc_t_d;

  logic [DATA_W:0] shifted;
  logic [DATA_W:0] diff;
  logic            qbit;

  assign shifted = {rem_q, quo_q[DATA_W-1]};
  assign diff    = shifted - {1'b0, dvs_q};
  assign qbit    = ~diff[DATA_W];

  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    dvs_d   = dvs_q;
    mul_s_d = mul_s_q;
    mul_t_d = mul_t_q;
    acc_s_d = acc_s_q;
    acc_t_d = acc_t_q;
    if (start_i) begin
      busy_d  = 1'b1;
      cnt_d   = cnt_t'(DATA_W - 1);
      rem_d   = '0;
      quo_d   = dividend_i;
      dvs_d   = divisor_i;
      mul_s_d = mul_s_i;
      mul_t_d = mul_t_i;
      acc_s_d = '0;
      acc_t_d = '0;
    end else if (busy_q) begin
      rem_d   = qbit ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
      quo_d   = {quo_q[DATA_W-2:0], 1'b0};
      // product mod 2^COEF_W, MSB first
      acc_s_d = (acc_s_q <<< 1) + (qbit ? mul_s_q : coef_t'(0));
      acc_t_d = (acc_t_q <<< 1) + (qbit ? mul_t_q : coef_t'(0));
      cnt_d   = cnt_q - cnt_t'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q   <= rem_d;
    quo_q   <= quo_d;
    dvs_q   <= dvs_d;
    mul_s_q <= mul_s_d;
    mul_t_q <= mul_t_d;
    acc_s_q <= acc_s_d;
    acc_t_q <= acc_t_d;
  end

  assign done_o   = done_q;
  assign rem_o    = rem_q;
  assign prod_s_o = acc_s_q;
  assign prod_t_o = acc_t_q;

endmodule

// ===== rtl/extended_gcd_bezout_core.sv =====
// Extended Euclidean core: gcd(a,b) and Bezout coefficients s, t.
// Each remainder step runs a start state, a 32-bit divide and a remainder check;
//   k steps (1..46 for 32-bit operands); a zero divisor skips the divider.
// One item in flight: a new operand pair is taken only once the last result
//   has gone to the output register; the bit-serial divider is shared by every step.
// Reset: rst_ni asynchronous active low, clears sequencer and output valid.
`timescale 1ns / 1ps

module extended_gcd_bezout_core import egcd_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  // input channel
  input  logic  in_valid_i,
  output logic  in_stall_o,
  input  data_t operand_a_i,
  input  data_t operand_b_i,
  // result channel
  output logic  out_valid_o,
  input  logic  out_stall_i,
  output data_t gcd_value_o,
  output coef_t coeff_s_o,
  output coef_t coeff_t_o,
  output logic  zero_divisor_o
);

  egcd_state_e state_q, state_d;

  // working set: dividend a, divisor b, coefficient pairs
  data_t a_q, a_d;
  data_t b_q, b_d;
  coef_t s_prev_q, s_prev_d;
  coef_t s_cur_q, s_cur_d;
  coef_t t_prev_q, t_prev_d;
  coef_t t_cur_q, t_cur_d;
  logic  flag_q, flag_d;

  // output register, parts the result side from the sequencer
  logic  out_valid_q, out_valid_d;
  data_t out_g_q, out_g_d;
  coef_t out_s_q, out_s_d;
  coef_t out_t_q, out_t_d;
  logic  out_z_q, out_z_d;

  logic  div_start;
  logic  div_done;
  data_t div_rem;
  coef_t prod_s;
  coef_t prod_t;
  logic  in_xfer;
  logic  out_free;

  egcd_div_unit u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (a_q),
    .divisor_i  (b_q),
    .mul_s_i    (s_cur_q),
    .mul_t_i    (t_cur_q),
    .done_o     (div_done),
    .rem_o      (div_rem),
    .prod_s_o   (prod_s),
    .prod_t_o   (prod_t)
  );

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i && (state_q == ST_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    a_d         = a_q;
    b_d         = b_q;
    s_prev_d    = s_prev_q;
    s_cur_d     = s_cur_q;
    t_prev_d    = t_prev_q;
    t_cur_d     = t_cur_q;
    flag_d      = flag_q;
    div_start   = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    out_g_d     = out_g_q;
    out_s_d     = out_s_q;
    out_t_d     = out_t_q;
    out_z_d     = out_z_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          a_d      = operand_a_i;
          s_prev_d = coef_t'(1);
          t_prev_d = coef_t'(0);
          if (operand_b_i == '0) begin
            // zero divisor: gcd=a, s=1, t=0, flagged
            b_d     = operand_a_i;
            s_cur_d = coef_t'(1);
            t_cur_d = coef_t'(0);
            flag_d  = 1'b1;
            state_d = ST_FIN;
          end else begin
            b_d     = operand_b_i;
            s_cur_d = coef_t'(0);
            t_cur_d = coef_t'(1);
            flag_d  = 1'b0;
            state_d = ST_START;
          end
        end
      end
      ST_START: begin
        div_start = 1'b1;
        state_d   = ST_WAIT;
      end
      ST_WAIT: begin
        if (div_done) begin
          if (div_rem == '0) begin
            // divisor of this step is the gcd, current pair is the answer
            state_d = ST_FIN;
          end else begin
            s_prev_d = s_cur_q;
            s_cur_d  = s_prev_q - prod_s;
            t_prev_d = t_cur_q;
            t_cur_d  = t_prev_q - prod_t;
            a_d      = b_q;
            b_d      = div_rem;
            state_d  = ST_START;
          end
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_g_d     = b_q;
          out_s_d     = s_cur_q;
          out_t_d     = t_cur_q;
          out_z_d     = flag_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q      <= a_d;
    b_q      <= b_d;
    s_prev_q <= s_prev_d;
    s_cur_q  <= s_cur_d;
    t_prev_q <= t_prev_d;
    t_cur_q  <= t_cur_d;
    flag_q   <= flag_d;
    out_g_q  <= out_g_d;
    out_s_q  <= out_s_d;
    out_t_q  <= out_t_d;
    out_z_q  <= out_z_d;
  end

  assign out_valid_o    = out_valid_q;
  assign gcd_value_o    = out_g_q;
  assign coeff_s_o      = out_s_q;
  assign coeff_t_o      = out_t_q;
  assign zero_divisor_o = out_z_q;

endmodule

// ===== tb/sv/tb_extended_gcd_bezout_core.sv =====
// Self-checking testbench for extended_gcd_bezout_core: gcd and Bezout pairs
// are checked against a built-in predictor through a small scoreboard class.
// Depends on egcd_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb_extended_gcd_bezout_core import egcd_pkg::*;;

  localparam int unsigned CLK_PERIOD  = 10;
  localparam int unsigned RESET_LEN   = 12;
  localparam int unsigned RAND_ITEMS  = 348;
  localparam int unsigned DRAIN_AT    = 180;
  // covers the worst item plus the longest stall on either side, with margin
  localparam int unsigned QUIET_LIMIT = 10000;
  // trailing cycles after the last expected transfer, enough to catch strays
  localparam int unsigned TAIL_CYCLES = 100;
  localparam int unsigned STEP_LIMIT  = 2 * DATA_W + 4;
  localparam data_t       ALL_ONES    = '1;

  typedef struct {
    data_t gcd;
    coef_t s;
    coef_t t;
    logic  zero_div;
  } bezout_result_t;

  // Holds the expected gcd/coefficient sets in acceptance order.
  class bezout_scoreboard;
    bezout_result_t expected_q[$];
    int unsigned    checked;
    int unsigned    mismatches;
    int unsigned    zero_div_results;

    // Euclid with running coefficient pairs, 64-bit wrapping arithmetic.
    function bezout_result_t predict(data_t a_in, data_t b_in);
      logic [63:0]    a, b, q, r;
      logic [63:0]    s_prev, s_cur, t_prev, t_cur, s_next, t_next;
      bezout_result_t res;
      int unsigned    step;
      bit             done;
      a = 64'(a_in);
      b = 64'(b_in);
      s_prev = 64'd1;
      s_cur = 64'd0;
      t_prev = 64'd0;
      t_cur = 64'd1;
      if (b == 64'd0) begin
        res.gcd = a_in;
        res.s = coef_t'(1);
        res.t = coef_t'(0);
        res.zero_div = 1'b1;
      end else begin
        res.zero_div = 1'b0;
        res.gcd = b[DATA_W-1:0];
        res.s = s_cur[COEF_W-1:0];
        res.t = t_cur[COEF_W-1:0];
        done = 1'b0;
        step = 0;
        while (!done && step < STEP_LIMIT && b != 64'd0) begin
          q = a / b;
          r = a % b;
          if (r == 64'd0) begin
            res.gcd = b[DATA_W-1:0];
            res.s = s_cur[COEF_W-1:0];
            res.t = t_cur[COEF_W-1:0];
            done = 1'b1;
          end else begin
            s_next = s_prev - s_cur * q;
            t_next = t_prev - t_cur * q;
            s_prev = s_cur;
            s_cur = s_next;
            t_prev = t_cur;
            t_cur = t_next;
            a = b;
            b = r;
          end
          step++;
        end
      end
      return res;
    endfunction

    function void note_operands(data_t a, data_t b);
      expected_q.push_back(predict(a, b));
    endfunction

    function void check_result(bezout_result_t got);
      bezout_result_t want;
      bit             bad;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result gcd=%0d s=%0d t=%0d zd=%0b",
                   got.gcd, got.s, got.t, got.zero_div);
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (want.zero_div)
        zero_div_results++;
      bad = (got.gcd !== want.gcd) || (got.s !== want.s) ||
            (got.t !== want.t) || (got.zero_div !== want.zero_div);
      if (bad) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: #%0d exp g=%0d s=%0d t=%0d z=%0b got g=%0d s=%0d t=%0d z=%0b",
                   checked, want.gcd, want.s, want.t, want.zero_div,
                   got.gcd, got.s, got.t, got.zero_div);
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic  clk = 1'b0;
  logic  rst_n;
  logic  in_valid;
  logic  in_stall;
  data_t operand_a;
  data_t operand_b;
  logic  out_valid;
  logic  out_stall;
  data_t gcd_value;
  coef_t coeff_s;
  coef_t coeff_t;
  logic  zero_divisor;

  bezout_scoreboard sb;

  // transfer flags, worked out at the falling edge for the next rising edge
  logic        in_fire = 1'b0;
  logic        out_fire = 1'b0;
  int unsigned quiet_cycles = 0;
  int unsigned sent_items = 0;
  logic        stall_quiet;
  int unsigned stall_hold = 0;
  logic [63:0] fib [0:48];

  always #(CLK_PERIOD / 2) clk = ~clk;

  extended_gcd_bezout_core dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .operand_a_i    (operand_a),
    .operand_b_i    (operand_b),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .gcd_value_o    (gcd_value),
    .coeff_s_o      (coeff_s),
    .coeff_t_o      (coeff_t),
    .zero_divisor_o (zero_divisor)
  );

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45)
      return 0;
    if (r < 88)
      return $urandom_range(1, 3);
    return $urandom_range(8, 120);
  endfunction

  // Both channels are sampled at the falling edge before the edge that takes the
  // transfer, so nothing hinges on the order of events at the rising edge.
  always @(negedge clk) begin
    bezout_result_t got;
    in_fire = rst_n && in_valid && !in_stall;
    out_fire = rst_n && out_valid && !out_stall;
    if (out_fire) begin
      got.gcd = gcd_value;
      got.s = coeff_s;
      got.t = coeff_t;
      got.zero_div = zero_divisor;
      sb.check_result(got);
    end
  end

  // Result side back-pressure: random hold periods of stall or no stall;
  // stall_quiet gives stretches with the receiver ready once any running stall ends.
  always @(posedge clk) begin
    if (stall_hold != 0) begin
      stall_hold <= stall_hold - 1;
    end else if (stall_quiet || $urandom_range(0, 2) != 0) begin
      out_stall <= 1'b0;
      stall_hold <= $urandom_range(0, 4);
    end else begin
      out_stall <= 1'b1;
      stall_hold <= pick_gap();
    end
  end

  // Watchdog: ends the run when nothing has moved on either channel for long.
  always @(posedge clk) begin
    if (!rst_n || in_fire || out_fire) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= QUIET_LIMIT) begin
        $display("ERROR: no transfer for %0d cycles", QUIET_LIMIT);
        $display("tb_extended_gcd_bezout_core failed");
        $finish;
      end
    end
  end

  // Offer one operand pair, note it on transfer, then optionally idle.
  // Called aligned to a rising edge; valid stays up across back-to-back items.
  task automatic send_operands(data_t a, data_t b, bit no_gap);
    int unsigned gap;
    operand_a <= a;
    operand_b <= b;
    in_valid <= 1'b1;
    do
      @(negedge clk);
    while (in_stall);
    sb.note_operands(a, b);
    sent_items++;
    @(posedge clk);
    gap = no_gap ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Sender holds off until every outstanding result has been taken.
  // When a result is still pending, valid drops first.
  task automatic wait_drained();
    if (sb.pending() != 0) begin
      in_valid <= 1'b0;
      while (sb.pending() != 0)
        @(posedge clk);
    end
  endtask

  // Random operand pair, weighted towards cases that exercise deep recursion
  // and the special cases rather than only uniform noise.
  task automatic pick_operands(output data_t a, output data_t b);
    int unsigned kind;
    int unsigned k;
    data_t       g;
    kind = $urandom_range(0, 99);
    if (kind < 30) begin
      a = $urandom();
      b = $urandom();
    end else if (kind < 45) begin
      a = $urandom_range(0, 255);
      b = $urandom_range(0, 255);
    end else if (kind < 58) begin
      // b divides a
      b = $urandom_range(1, 65535);
      a = b * data_t'($urandom_range(1, 65535));
    end else if (kind < 72) begin
      // shared factor
      g = $urandom_range(2, 4095);
      a = g * data_t'($urandom_range(1, 1 << 20));
      b = g * data_t'($urandom_range(1, 1 << 20));
    end else if (kind < 84) begin
      // neighbouring Fibonacci numbers: the longest remainder chains
      k = $urandom_range(1, 46);
      if ($urandom_range(0, 1) != 0) begin
        a = fib[k+1][DATA_W-1:0];
        b = fib[k][DATA_W-1:0];
      end else begin
        a = fib[k][DATA_W-1:0];
        b = fib[k+1][DATA_W-1:0];
      end
    end else if (kind < 90) begin
      a = $urandom();
      b = '0;
    end else if (kind < 95) begin
      a = '0;
      b = $urandom();
    end else begin
      a = $urandom_range(0, 1000);
      b = $urandom();
    end
  endtask

  initial begin
    data_t       ra, rb;
    int unsigned leftover;
    bit          quiet;
    sb = new();
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    operand_a <= '0;
    operand_b <= '0;
    out_stall <= 1'b0;
    stall_quiet <= 1'b0;
    fib[0] = 64'd0;
    fib[1] = 64'd1;
    for (int i = 2; i <= 48; i++)
      fib[i] = fib[i-1] + fib[i-2];

    repeat (RESET_LEN) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: both zero, zero divisor, zero first operand, field extremes,
    // b dividing a, a below b, the deepest Fibonacci chain, bit patterns.
    send_operands('0, '0, 1'b0);
    send_operands('0, 32'd1, 1'b0);
    send_operands(32'd1, '0, 1'b0);
    send_operands('0, ALL_ONES, 1'b0);
    send_operands(ALL_ONES, '0, 1'b0);
    send_operands(ALL_ONES, ALL_ONES, 1'b0);
    send_operands(ALL_ONES, 32'd1, 1'b0);
    send_operands(32'd1, ALL_ONES, 1'b0);
    send_operands(ALL_ONES, ALL_ONES - 1, 1'b0);
    send_operands(32'd240, 32'd46, 1'b0);
    send_operands(32'd46, 32'd240, 1'b0);
    send_operands(32'd100, 32'd25, 1'b0);
    send_operands(32'd25, 32'd100, 1'b0);
    send_operands(fib[47][DATA_W-1:0], fib[46][DATA_W-1:0], 1'b0);
    send_operands(fib[46][DATA_W-1:0], fib[47][DATA_W-1:0], 1'b0);
    send_operands(32'h8000_0000, 32'h4000_0000, 1'b0);
    send_operands(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    send_operands(32'hAAAA_AAAA, 32'h5555_5555, 1'b0);
    send_operands(32'h5555_5555, 32'hAAAA_AAAA, 1'b0);
    send_operands(32'd4294967291, 32'd4294967279, 1'b0);
    send_operands(32'd1, 32'd1, 1'b0);
    send_operands(32'd7, 32'd7, 1'b0);

    for (int unsigned i = 0; i < RAND_ITEMS; i++) begin
      // two windows with no idling on either side
      quiet = (i >= 60 && i < 100) || (i >= 250 && i < 280);
      stall_quiet <= quiet;
      if (i == DRAIN_AT)
        wait_drained();
      pick_operands(ra, rb);
      send_operands(ra, rb, quiet);
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    leftover = sb.pending();
    if (leftover != 0)
      $display("ERROR: %0d expected results never arrived", leftover);

    $display("Summary: %0d operand pairs sent, %0d results checked (%0d zero divisor)",
             sent_items, sb.checked, sb.zero_div_results);
    $display("Summary: %0d mismatching or unexpected results", sb.mismatches);
    if (sb.mismatches == 0 && leftover == 0) begin
      $display("tb_extended_gcd_bezout_core passed");
    end else begin
      $display("tb_extended_gcd_bezout_core failed");
    end
    $finish;
  end

endmodule
